/* sv/dnsd_pkg.sv */
// dnsd_pkg: constants, status codes and controller/datapath types of the DNS name decompressor
// no dependencies; imported by dnsd_ctrl, dnsd_datapath and dns_name_decompressor_top
`default_nettype none

package dnsd_pkg;

	localparam int MSG_BYTES     = 512;
	localparam int NAME_BYTES    = 256;
	localparam int MAX_HOPS      = 16;
	localparam int CHUNK_BYTES   = 8;
	localparam int POINTER_BYTES = 2;

	localparam int MSG_AW  = $clog2(MSG_BYTES);
	localparam int NAME_AW = $clog2(NAME_BYTES);
	localparam int MLEN_W  = 10;
	localparam int CAP_W   = 9;
	localparam int NCNT_W  = NAME_AW + 1;
	localparam int HOP_W   = 5;
	localparam int LEN_W   = 8;
	localparam int FS_W    = 10;
	localparam int CNT_W   = 4;
	localparam int CHUNK_W = 8 * CHUNK_BYTES;
	localparam int TGT_W   = 14;

	localparam int IN_W         = 32;
	localparam int OUT_FIELDS_W = CHUNK_W + CNT_W + LEN_W + FS_W;
	localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int CFG_W        = MLEN_W;

	localparam logic       MODE_LOAD    = 1'b0;
	localparam logic       MODE_DECODE  = 1'b1;
	localparam logic       CFG_MSG_LEN  = 1'b0;
	localparam logic       CFG_NAME_CAP = 1'b1;
	localparam logic [1:0] PTR_TAG      = 2'b11;
	localparam logic [7:0] DOT_CHAR     = 8'h2E;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_OOB      = 2'd2,
		ST_HOPS     = 2'd3
	} status_t;

	typedef struct packed {
		logic    load_wr;
		logic    start;
		logic    take_ptr;
		logic    take_label;
		logic    follow;
		logic    text_step;
		logic    dot_step;
		logic    finish;
		logic    gather;
		logic    push;
		logic    chunk_clear;
		logic    err_set;
		status_t err_code;
	} dnsd_cmd_t;

	typedef struct packed {
		logic cursor_oob;
		logic byte_zero;
		logic byte_ptr;
		logic too_long;
		logic label_oob;
		logic hops_full;
		logic target_oob;
		logic rem_last;
		logic cap_zero;
		logic cap_none;
		logic chunk_full;
		logic name_done;
		logic out_free;
		logic err_pending;
	} dnsd_stat_t;

endpackage

`default_nettype wire

/* sv/dnsd_ctrl.sv */
// dnsd_ctrl: state machine that sequences load, name walk, chunk gather and result push
// depends on dnsd_pkg; drives dnsd_datapath through dnsd_cmd_t
`default_nettype none

module dnsd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_mode,
	output logic                     in_ready,
	input  wire dnsd_pkg::dnsd_stat_t stat,
	output dnsd_pkg::dnsd_cmd_t      cmd
);
	import dnsd_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_HEAD   = 7'b0000010,
		S_PTR2   = 7'b0000100,
		S_TEXT   = 7'b0001000,
		S_DOT    = 7'b0010000,
		S_GATHER = 7'b0100000,
		S_PUSH   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_mode == MODE_DECODE) begin
						cmd.start = 1'b1;
						state_d   = S_HEAD;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			S_HEAD: begin
				if (stat.cursor_oob) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = ST_OOB;
					state_d      = S_PUSH;
				end else if (stat.byte_zero) begin
					if (stat.cap_none) begin
						cmd.err_set  = 1'b1;
						cmd.err_code = ST_TOO_LONG;
						state_d      = S_PUSH;
					end else begin
						cmd.finish = 1'b1;
						state_d    = S_GATHER;
					end
				end else if (stat.byte_ptr) begin
					cmd.take_ptr = 1'b1;
					state_d      = S_PTR2;
				end else if (stat.too_long) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = ST_TOO_LONG;
					state_d      = S_PUSH;
				end else if (stat.label_oob) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = ST_OOB;
					state_d      = S_PUSH;
				end else begin
					cmd.take_label = 1'b1;
					state_d        = S_TEXT;
				end
			end
			S_PTR2: begin
				if (stat.cursor_oob) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = ST_OOB;
					state_d      = S_PUSH;
				end else if (stat.hops_full) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = ST_HOPS;
					state_d      = S_PUSH;
				end else if (stat.target_oob) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = ST_OOB;
					state_d      = S_PUSH;
				end else begin
					cmd.follow = 1'b1;
					state_d    = S_HEAD;
				end
			end
			S_TEXT: begin
				cmd.text_step = 1'b1;
				if (stat.rem_last) begin
					state_d = S_DOT;
				end
			end
			S_DOT: begin
				if (stat.cap_zero) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = ST_TOO_LONG;
					state_d      = S_PUSH;
				end else begin
					cmd.dot_step = 1'b1;
					state_d      = S_HEAD;
				end
			end
			S_GATHER: begin
				if (stat.chunk_full || stat.name_done) begin
					state_d = S_PUSH;
				end else begin
					cmd.gather = 1'b1;
				end
			end
			S_PUSH: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					if (stat.err_pending || stat.name_done) begin
						state_d = S_IDLE;
					end else begin
						cmd.chunk_clear = 1'b1;
						state_d         = S_GATHER;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* sv/dnsd_datapath.sv */
// dnsd_datapath: message and name stores, walk counters, chunk assembly and output register
// depends on dnsd_pkg; commanded by dnsd_ctrl
`default_nettype none

module dnsd_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire dnsd_pkg::dnsd_cmd_t            cmd,
	output dnsd_pkg::dnsd_stat_t                stat,
	input  wire logic                           cfg_wr,
	input  wire logic                           cfg_sel,
	input  wire logic [dnsd_pkg::CFG_W-1:0]     cfg_value,
	input  wire logic [dnsd_pkg::MSG_AW-1:0]    load_address,
	input  wire logic [7:0]                     data_byte,
	input  wire logic [dnsd_pkg::MSG_AW-1:0]    start_offset,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic [dnsd_pkg::OUT_W-1:0]          out_data,
	output logic                                out_last,
	output dnsd_pkg::status_t                   out_status
);
	import dnsd_pkg::*;

	localparam logic [MLEN_W-1:0] MLEN_MAX = MLEN_W'(MSG_BYTES);
	localparam logic [CAP_W-1:0]  CAP_MAX  = CAP_W'(NAME_BYTES);

	logic [7:0]          msg_mem [MSG_BYTES];
	logic [7:0]          name_mem [NAME_BYTES];

	logic [MLEN_W-1:0]   mlen_q;
	logic [CAP_W-1:0]    cap_q;
	logic [MLEN_W-1:0]   mlen_eff;
	logic [CAP_W-1:0]    cap_eff;

	logic [MLEN_W-1:0]   cursor_q, cursor_d;
	logic [7:0]          msg_q;
	logic [CAP_W-1:0]    capleft_q;
	logic                inline_flag_q;
	logic [FS_W-1:0]     inline_q;
	logic [HOP_W-1:0]    hop_q;
	logic [NCNT_W-1:0]   n_q;
	logic [7:0]          rem_q;
	logic [5:0]          ptr_hi_q;
	logic [TGT_W-1:0]    target;
	status_t             status_q;

	logic [LEN_W-1:0]    len_q;
	logic [NAME_AW-1:0]  ptr_q, ptr_d;
	logic [7:0]          nrd_q;
	logic [CHUNK_W-1:0]  word_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                name_wr;
	logic [7:0]          name_wdata;

	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;
	logic                out_last_q;
	status_t             out_status_q;
	logic [OUT_FIELDS_W-1:0] push_fields;

	assign mlen_eff = (mlen_q > MLEN_MAX) ? MLEN_MAX : mlen_q;
	assign cap_eff  = (cap_q > CAP_MAX) ? CAP_MAX : cap_q;
	assign target   = {ptr_hi_q, msg_q};

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mlen_q <= '0;
			cap_q  <= CAP_MAX;
		end else if (cfg_wr) begin
			if (cfg_sel == CFG_MSG_LEN) begin
				mlen_q <= cfg_value[MLEN_W-1:0];
			end else begin
				cap_q <= cfg_value[CAP_W-1:0];
			end
		end
	end

	always_comb begin
		cursor_d = cursor_q;
		if (cmd.start) begin
			cursor_d = {1'b0, start_offset};
		end else if (cmd.take_ptr || cmd.take_label || cmd.text_step) begin
			cursor_d = cursor_q + MLEN_W'(1);
		end else if (cmd.follow) begin
			cursor_d = target[MLEN_W-1:0];
		end
	end

	// message store, read at the next cursor so msg_q follows cursor_q
	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			msg_mem[load_address] <= data_byte;
		end
		msg_q <= msg_mem[cursor_d[MSG_AW-1:0]];
	end

	assign name_wr    = cmd.text_step || cmd.dot_step;
	assign name_wdata = cmd.dot_step ? DOT_CHAR : msg_q;

	always_comb begin
		ptr_d = ptr_q;
		if (cmd.finish) begin
			ptr_d = '0;
		end else if (cmd.gather) begin
			ptr_d = ptr_q + NAME_AW'(1);
		end
	end

	// name store, read at the next gather pointer
	always_ff @(posedge clk) begin
		if (name_wr) begin
			name_mem[n_q[NAME_AW-1:0]] <= name_wdata;
		end
		nrd_q <= name_mem[ptr_d];
	end

	// walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q      <= '0;
			capleft_q     <= '0;
			inline_flag_q <= 1'b1;
			inline_q      <= '0;
			hop_q         <= '0;
			n_q           <= '0;
			rem_q         <= '0;
			ptr_hi_q      <= '0;
			status_q      <= ST_OK;
			len_q         <= '0;
		end else begin
			cursor_q <= cursor_d;
			if (cmd.start) begin
				capleft_q     <= cap_eff;
				inline_flag_q <= 1'b1;
				inline_q      <= '0;
				hop_q         <= '0;
				n_q           <= '0;
				status_q      <= ST_OK;
			end
			if (cmd.err_set) begin
				status_q <= cmd.err_code;
			end
			if (cmd.take_ptr) begin
				ptr_hi_q <= msg_q[5:0];
				if (inline_flag_q) begin
					inline_q      <= inline_q + FS_W'(POINTER_BYTES);
					inline_flag_q <= 1'b0;
				end
			end
			if (cmd.follow) begin
				hop_q <= hop_q + HOP_W'(1);
			end
			if (cmd.take_label) begin
				rem_q <= msg_q;
			end
			if (cmd.text_step) begin
				rem_q     <= rem_q - 8'd1;
				n_q       <= n_q + NCNT_W'(1);
				capleft_q <= capleft_q - CAP_W'(1);
				if (inline_flag_q) begin
					inline_q <= inline_q + FS_W'(1);
				end
			end
			if (cmd.dot_step) begin
				n_q       <= n_q + NCNT_W'(1);
				capleft_q <= capleft_q - CAP_W'(1);
				if (inline_flag_q) begin
					inline_q <= inline_q + FS_W'(1);
				end
			end
			if (cmd.finish) begin
				// drop the trailing dot unless the name is empty
				if (capleft_q != cap_eff) begin
					len_q <= LEN_W'(n_q - NCNT_W'(1));
				end else begin
					len_q <= '0;
				end
				if (inline_flag_q) begin
					inline_q <= inline_q + FS_W'(1);
				end
			end
		end
	end

	// chunk assembly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			ptr_q <= ptr_d;
			if (cmd.finish || cmd.chunk_clear) begin
				cnt_q <= '0;
			end else if (cmd.gather) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish || cmd.chunk_clear) begin
			word_q <= '0;
		end else if (cmd.gather) begin
			word_q[{cnt_q[2:0], 3'b000} +: 8] <= nrd_q;
		end
	end

	// output register
	always_comb begin
		if (status_q != ST_OK) begin
			push_fields = '0;
		end else if (ptr_q == len_q) begin
			push_fields = {inline_q, len_q, cnt_q, word_q};
		end else begin
			push_fields = {FS_W'(0), LEN_W'(0), cnt_q, word_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_data_q   <= OUT_W'(push_fields);
			out_last_q   <= (status_q != ST_OK) || (ptr_q == len_q);
			out_status_q <= status_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

	always_comb begin
		stat.cursor_oob  = (cursor_q >= mlen_eff);
		stat.byte_zero   = (msg_q == 8'd0);
		stat.byte_ptr    = (msg_q[7:6] == PTR_TAG);
		stat.too_long    = ({1'b0, msg_q} > capleft_q);
		stat.label_oob   = (({1'b0, cursor_q} + (MLEN_W+1)'(1) + (MLEN_W+1)'(msg_q))
			> {1'b0, mlen_eff});
		stat.hops_full   = (hop_q >= HOP_W'(MAX_HOPS));
		stat.target_oob  = (target >= TGT_W'(mlen_eff));
		stat.rem_last    = (rem_q == 8'd1);
		stat.cap_zero    = (capleft_q == '0);
		stat.cap_none    = (cap_eff == '0);
		stat.chunk_full  = (cnt_q == CNT_W'(CHUNK_BYTES));
		stat.name_done   = (ptr_q == len_q);
		stat.out_free    = !out_valid_q || out_ready;
		stat.err_pending = (status_q != ST_OK);
	end

endmodule

`default_nettype wire

/* sv/dns_name_decompressor_top.sv */
// dns_name_decompressor_top: DNS name decompressor, stream in, stream out, config write channel
// depends on dnsd_pkg, dnsd_ctrl and dnsd_datapath
//
//  channel  | signals                                   | carries
//  s_axis   | tvalid tready tdata[31:0] tuser           | load byte or decode request
//  m_axis   | tvalid tready tdata[87:0] tuser[1:0] tlast| name chunks, status on tuser
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data    | message_length, name_capacity
//
// a decode walks one message byte per cycle through the single message-store read port:
// a label passes the head, text and dot states, a pointer the head and second pointer byte
// states, the end byte the head state; then 8-byte chunks pass the single name-store port
// reset clears control and config only; both stores are undefined until written
// a full output register holds the walk in its push state; a decode request can be taken
// while the last result still waits
`default_nettype none

module dns_name_decompressor_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// load_address[8:0], data_byte[16:9], start_offset[25:17], zero fill
	input  wire logic [dnsd_pkg::IN_W-1:0]    s_axis_tdata,
	// mode
	input  wire logic                         s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// name_chunk[63:0], chunk_bytes[67:64], name_length[75:68], field_size[85:76], zero fill
	output logic [dnsd_pkg::OUT_W-1:0]        m_axis_tdata,
	// status
	output logic [1:0]                        m_axis_tuser,
	output logic                              m_axis_tlast,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         cfg_index,
	input  wire logic [dnsd_pkg::CFG_W-1:0]   cfg_data
);
	import dnsd_pkg::*;

	dnsd_cmd_t  cmd;
	dnsd_stat_t stat;
	status_t    out_status;
	logic       in_ready;

	assign s_axis_tready = in_ready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tuser  = out_status;

	dnsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dnsd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_sel      (cfg_index),
		.cfg_value    (cfg_data),
		.load_address (s_axis_tdata[MSG_AW-1:0]),
		.data_byte    (s_axis_tdata[MSG_AW+7:MSG_AW]),
		.start_offset (s_axis_tdata[2*MSG_AW+7:MSG_AW+8]),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_data     (m_axis_tdata),
		.out_last     (m_axis_tlast),
		.out_status   (out_status)
	);

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result pushed over a pending result");

	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_DECODE) |=> !s_axis_tready)
		else $error("decode request did not start a walk");

	a_walk_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.take_ptr, cmd.take_label, cmd.follow,
			cmd.text_step, cmd.dot_step, cmd.finish, cmd.gather}))
		else $error("conflicting walk commands");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_OK) |-> m_axis_tlast)
		else $error("error result not marked last");
`endif

endmodule

`default_nettype wire

/* tb/dns_name_decompressor_top_tb.sv */
// dns_name_decompressor_top_tb: self-checking bench for the dns name decompressor
// depends on dnsd_pkg and dns_name_decompressor_top; loads messages, decodes names and
// compares every name chunk with a predictor of the label walk kept in the bench

module dns_name_decompressor_top_tb;
	import dnsd_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic       mode;
		logic [8:0] addr;
		logic [7:0] data;
		logic [8:0] start;
	} name_req_t;

	typedef struct packed {
		logic [63:0] chunk;
		logic [3:0]  nbytes;
		logic        last;
		status_t     status;
		logic [7:0]  len;
		logic [9:0]  fsize;
	} name_beat_t;

	typedef struct packed {
		status_t status;
		int      len;
		int      fsize;
	} walk_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_PATTERN
	} rx_mode_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             s_axis_tuser = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [1:0]       m_axis_tuser;
	logic             m_axis_tlast;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic [7:0] msg_mem [MSG_BYTES];
	logic [7:0] plan_mem [MSG_BYTES];
	bit         plan_wr [MSG_BYTES];
	logic [7:0] name_buf [NAME_BYTES];
	int         dut_mlen = 0;
	int         dut_cap = NAME_BYTES;
	int         plan_mlen = 0;
	int         plan_cap = NAME_BYTES;
	bit         plan_unsafe;

	name_req_t  req_q[$];
	name_beat_t chunk_q[$];
	int         name_starts[$];
	name_req_t  s_cur;
	int         req_sent = 0;
	int         req_taken = 0;
	bit         s_fire = 1'b0;
	bit         c_fire = 1'b0;
	int         fail_cnt = 0;
	int         cycle = 0;
	int         wr_ptr = 16;
	int         burst_left = 1;
	int         gap_left = 0;
	bit         hold_arm = 1'b0;
	bit         hold_done = 1'b0;
	int         hold_left = 0;
	int         pat_left = 0;
	rx_mode_t   pat_mode = RX_OPEN;
	logic [7:0] pat_bits = 8'hFF;

	dns_name_decompressor_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// planned reads flag any byte the stimulus never loaded
	function automatic logic [7:0] msg_rd(input bit planned, input int pos);
		if (planned) begin
			if (!plan_wr[pos])
				plan_unsafe = 1'b1;
			return plan_mem[pos];
		end
		return msg_mem[pos];
	endfunction

	function automatic walk_t walk_name(input bit planned, input int start, input int mlen_reg,
			input int cap_reg);
		walk_t      res;
		logic [7:0] b;
		logic [7:0] ch;
		int         mlen, cap, cur, room, n, hops, tgt, fs, i;
		bit         inl;
		res.status = ST_OK;
		res.len = 0;
		res.fsize = 0;
		mlen = (mlen_reg > MSG_BYTES) ? MSG_BYTES : mlen_reg;
		cap = (cap_reg > NAME_BYTES) ? NAME_BYTES : cap_reg;
		cur = start;
		room = cap;
		n = 0;
		hops = 0;
		fs = 0;
		inl = 1'b1;
		forever begin
			if (cur >= mlen) begin
				res.status = ST_OOB;
				return res;
			end
			b = msg_rd(planned, cur);
			cur++;
			if (b == 8'd0)
				break;
			if (b[7:6] == PTR_TAG) begin
				if (inl) begin
					fs += POINTER_BYTES;
					inl = 1'b0;
				end
				if (cur >= mlen) begin
					res.status = ST_OOB;
					return res;
				end
				tgt = {b[5:0], msg_rd(planned, cur)};
				if (hops >= MAX_HOPS) begin
					res.status = ST_HOPS;
					return res;
				end
				hops++;
				if (tgt >= mlen) begin
					res.status = ST_OOB;
					return res;
				end
				cur = tgt;
				continue;
			end
			// top bits 01 and 10 count as a plain label length
			if (int'(b) > room) begin
				res.status = ST_TOO_LONG;
				return res;
			end
			if (cur + int'(b) > mlen) begin
				res.status = ST_OOB;
				return res;
			end
			for (i = 0; i < int'(b); i++) begin
				ch = msg_rd(planned, cur + i);
				if (!planned)
					name_buf[(n + i) % NAME_BYTES] = ch;
			end
			n += int'(b);
			room -= int'(b);
			cur += int'(b);
			if (inl)
				fs += int'(b) + 1;
			if (room < 1) begin
				res.status = ST_TOO_LONG;
				return res;
			end
			if (!planned)
				name_buf[n % NAME_BYTES] = DOT_CHAR;
			n++;
			room--;
		end
		// drop the trailing dot, or reserve the terminator of an empty name
		if (room != cap) begin
			n--;
		end else if (room < 1) begin
			res.status = ST_TOO_LONG;
			return res;
		end
		if (inl)
			fs++;
		res.len = n;
		res.fsize = fs;
		return res;
	endfunction

	function automatic void predict_chunks(input int start);
		walk_t      res;
		name_beat_t beat;
		int         nchunks, k, i;
		res = walk_name(1'b0, start, dut_mlen, dut_cap);
		if (res.status != ST_OK) begin
			beat = '0;
			beat.last = 1'b1;
			beat.status = res.status;
			chunk_q.push_back(beat);
			return;
		end
		nchunks = (res.len + CHUNK_BYTES - 1) / CHUNK_BYTES;
		if (nchunks == 0)
			nchunks = 1;
		for (k = 0; k < nchunks; k++) begin
			beat = '0;
			beat.status = ST_OK;
			for (i = 0; i < CHUNK_BYTES && k * CHUNK_BYTES + i < res.len; i++) begin
				beat.chunk[8 * i +: 8] = name_buf[(k * CHUNK_BYTES + i) % NAME_BYTES];
				beat.nbytes++;
			end
			if (k == nchunks - 1) begin
				beat.last = 1'b1;
				beat.len = 8'(res.len);
				beat.fsize = 10'(res.fsize);
			end
			chunk_q.push_back(beat);
		end
	endfunction

	function automatic void check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", field, want, got);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		name_beat_t want;
		cycle++;
		if (cycle > CYCLE_LIMIT) begin
			$display("dns_name_decompressor_top: mismatch");
			$finish;
		end else begin
			s_fire = arst_n && s_axis_tvalid && s_axis_tready;
			c_fire = arst_n && cfg_valid && cfg_ready;
			if (s_fire) begin
				req_taken++;
				if (s_cur.mode == MODE_LOAD)
					msg_mem[s_cur.addr] = s_cur.data;
				else
					predict_chunks(s_cur.start);
			end
			if (c_fire) begin
				if (cfg_index == CFG_MSG_LEN)
					dut_mlen = cfg_data;
				else
					dut_cap = cfg_data[CAP_W-1:0];
			end
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (chunk_q.size() == 0) begin
					$error("name chunk with no request pending");
					fail_cnt++;
				end else begin
					want = chunk_q.pop_front();
					check_field("name_chunk", want.chunk, m_axis_tdata[63:0]);
					check_field("chunk_bytes", want.nbytes, m_axis_tdata[67:64]);
					check_field("last", want.last, m_axis_tlast);
					check_field("status", want.status, m_axis_tuser);
					check_field("name_length", want.len, m_axis_tdata[75:68]);
					check_field("field_size", want.fsize, m_axis_tdata[85:76]);
				end
			end
		end
	end

	// sender: bursts of requests with random gaps
	always @(negedge clk) begin : drive_req
		if (arst_n && (!s_axis_tvalid || s_fire)) begin
			if (s_fire) begin
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) :
						$urandom_range(0, 2);
				end
			end
			if (gap_left > 0 || req_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				s_axis_tvalid <= 1'b0;
			end else begin
				s_cur = req_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= IN_W'({s_cur.start, s_cur.data, s_cur.addr});
				s_axis_tuser <= s_cur.mode;
			end
		end
	end

	// receiver: stall pattern redrawn from four modes when its counter runs out, one long hold-off when armed
	always @(negedge clk) begin : drive_ready
		if (hold_arm && !hold_done && m_axis_tvalid) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (pat_left == 0) begin
			pat_left = 64;
			pat_mode = rx_mode_t'($urandom_range(0, 3));
			pat_bits = 8'($urandom) | 8'h01;
		end
		pat_left--;
		pat_bits = {pat_bits[6:0], pat_bits[7]};
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (pat_mode)
				RX_OPEN: m_axis_tready <= 1'b1;
				RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
				RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 4) != 0);
				default: m_axis_tready <= pat_bits[0];
			endcase
		end
	end

	function automatic void plan_load(input int addr, input int val);
		name_req_t req;
		req.mode = MODE_LOAD;
		req.addr = 9'(addr);
		req.data = 8'(val);
		req.start = 9'($urandom);
		plan_mem[addr] = 8'(val);
		plan_wr[addr] = 1'b1;
		req_q.push_back(req);
		req_sent++;
	endfunction

	function automatic void put_byte(input int val);
		plan_load(wr_ptr, val);
		wr_ptr++;
	endfunction

	// a decode that would touch an unloaded byte is not sent
	function automatic void plan_decode(input int start);
		name_req_t req;
		plan_unsafe = 1'b0;
		void'(walk_name(1'b1, start, plan_mlen, plan_cap));
		if (plan_unsafe)
			return;
		req.mode = MODE_DECODE;
		req.addr = 9'($urandom);
		req.data = 8'($urandom);
		req.start = 9'(start);
		req_q.push_back(req);
		req_sent++;
	endfunction

	function automatic int recent_start();
		if ($urandom_range(0, 1) == 1)
			return name_starts[name_starts.size() - 1];
		return name_starts[$urandom_range(0, name_starts.size() - 1)];
	endfunction

	function automatic void plan_name();
		int lens [4];
		int nlab, size, at, i, j, tail, tgt;
		nlab = $urandom_range(0, 4);
		size = 1;
		for (i = 0; i < nlab; i++) begin
			lens[i] = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 72) :
				$urandom_range(1, 12);
			size += lens[i] + 1;
		end
		// tail: pointer to an earlier name, wild pointer, garbage byte or end byte
		tail = $urandom_range(0, 9);
		if (tail <= 5)
			size++;
		if (wr_ptr + size > MSG_BYTES)
			wr_ptr = $urandom_range(0, 31);
		at = wr_ptr;
		for (i = 0; i < nlab; i++) begin
			put_byte(lens[i]);
			for (j = 0; j < lens[i]; j++)
				put_byte($urandom_range(0, 255));
		end
		if (tail <= 5) begin
			if (tail <= 4 && name_starts.size() > 0)
				tgt = recent_start();
			else
				tgt = ($urandom_range(0, 1) == 1) ? at : $urandom_range(0, 16'h3FFF);
			put_byte({PTR_TAG, 6'(tgt >> 8)});
			put_byte(8'(tgt));
		end else if (tail == 6) begin
			put_byte($urandom_range(0, 255));
		end else begin
			put_byte(0);
		end
		name_starts.push_back(at);
		if (name_starts.size() > 48)
			void'(name_starts.pop_front());
	endfunction

	function automatic void plan_phase(input int n_items);
		int goal, pick;
		goal = req_sent + n_items;
		while (req_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				plan_name();
			else if (pick < 82 && name_starts.size() > 0)
				plan_decode(recent_start());
			else if (pick < 92)
				plan_decode($urandom_range(0, MSG_BYTES - 1));
			else
				plan_load($urandom_range(0, MSG_BYTES - 1), $urandom_range(0, 255));
		end
	endfunction

	task automatic settle();
		do @(negedge clk); while (req_taken != req_sent || chunk_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!c_fire);
	endtask

	task automatic set_regs(input int mlen, input int cap);
		write_reg(CFG_MSG_LEN, CFG_W'(mlen));
		write_reg(CFG_NAME_CAP, CFG_W'(cap));
		cfg_valid <= 1'b0;
		plan_mlen = mlen;
		plan_cap = cap;
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message after reset
		plan_decode(0);
		settle();

		set_regs(16, NAME_BYTES);
		plan_load(0, 8'h00);
		plan_decode(0);
		plan_load(1, 8'h02);
		plan_load(2, 8'hFF);
		plan_load(3, 8'h00);
		plan_load(4, 8'h00);
		plan_decode(1);
		plan_load(5, {PTR_TAG, 6'h00});
		plan_load(6, 8'h01);
		plan_decode(5);
		// pointer to itself runs out of hops
		plan_load(7, {PTR_TAG, 6'h00});
		plan_load(8, 8'h07);
		plan_decode(7);
		// reserved label types taken as long lengths
		plan_load(9, 8'h41);
		plan_decode(9);
		plan_load(10, 8'h85);
		plan_decode(10);
		plan_load(11, {PTR_TAG, 6'h3F});
		plan_load(12, 8'hFF);
		plan_decode(11);
		plan_load(15, {PTR_TAG, 6'h00});
		plan_decode(15);
		plan_decode(MSG_BYTES - 1);
		plan_load(MSG_BYTES - 1, 8'hAA);
		settle();

		hold_arm = 1'b1;
		set_regs(MSG_BYTES, NAME_BYTES);
		plan_phase(64);
		settle();
		set_regs(200, 12);
		plan_phase(40);
		settle();
		set_regs(1023, 511);
		plan_phase(48);
		settle();
		set_regs(300, 0);
		plan_phase(12);
		settle();
		set_regs(MSG_BYTES, 1);
		plan_phase(16);
		settle();
		set_regs(480, 64);
		plan_phase(64);
		settle();

		if (fail_cnt == 0 && chunk_q.size() == 0)
			$display("dns_name_decompressor_top: match");
		else
			$display("dns_name_decompressor_top: mismatch");
		$finish;
	end

endmodule
